// File: rtl/ssopa_pkg.sv
// Shared types and constants for the sign-split outer-product accumulator.
// No dependencies; imported by ssopa_mul and the top level.
package ssopa_pkg;

    localparam int DEF_ROWS = 64;
    localparam int DEF_COLS = 64;

    localparam int IDX_W   = 6;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 48;
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int EXACT_W = 46;
    localparam int MAG_W   = 31;
    localparam int RND_SH  = 15;

    localparam logic [ACC_W-1:0]   ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [EXACT_W-1:0] RND_BIAS = EXACT_W'(1) << (RND_SH - 1);

    typedef enum logic [1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RND,
        S_DONE
    } state_t;

endpackage

// File: rtl/ssopa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssopa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ssopa_mul.sv
// Shared 31x16 unsigned multiplier with its product register.
// Depends on ssopa_pkg for operand and product widths.
module ssopa_mul import ssopa_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  product
);

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign product = product_reg;

endmodule

// File: rtl/sign_split_outer_product_accumulate.sv
// Top level of the sign-split outer-product accumulator: sequencer, two stores.
// Depends on ssopa_pkg, ssopa_ram and ssopa_mul.
//
//   channel | direction | handshake          | payload
//   in      | receive   | in_valid/in_stall  | cmd row col alpha a_value b_value
//   out     | send      | out_valid/out_stall| plus_value minus_value saturated
//
// An accumulate runs through transfer with store read, two passes through the
// shared multiplier, rounding, then saturating add and write-back.
// Read, clear and out-of-range items go from transfer straight to result.
// After reset a clearing pass zeroes every entry of both stores, in_stall high.
// The result sits in an output register; write-back waits while it is still held.
module sign_split_outer_product_accumulate import ssopa_pkg::*; #(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [IDX_W-1:0]        row,
    input  logic [IDX_W-1:0]        col,
    input  logic signed [VAL_W-1:0] alpha,
    input  logic signed [VAL_W-1:0] a_value,
    input  logic signed [VAL_W-1:0] b_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [ACC_W-1:0]        plus_value,
    output logic [ACC_W-1:0]        minus_value,
    output logic                    saturated
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic             ok_reg, ok_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] ua_reg, ua_next;
    logic [VAL_W-1:0] ux_reg, ux_next;
    logic [VAL_W-1:0] ub_reg, ub_next;
    logic [MAG_W-1:0] mag_reg, mag_next;

    logic             out_valid_reg, out_valid_next;
    logic [ACC_W-1:0] plus_value_reg, plus_value_next;
    logic [ACC_W-1:0] minus_value_reg, minus_value_next;
    logic             saturated_reg, saturated_next;

    logic               accept;
    logic               out_free;
    logic [AW-1:0]      idx_now;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ACC_W-1:0]   plus_wdata, minus_wdata;
    logic [ACC_W-1:0]   plus_rdata, minus_rdata;
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [EXACT_W-1:0] rnd_sum;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_new;
    logic               acc_sat;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign idx_now  = AW'(32'(row) * 32'(COLS) + 32'(col));
    assign in_stall = (state_reg != S_IDLE);

    assign rnd_sum = mul_p[EXACT_W-1:0] + RND_BIAS;
    assign acc_sum = {1'b0, (neg_reg ? minus_rdata : plus_rdata)} + (ACC_W + 1)'(mag_reg);
    assign acc_sat = acc_sum[ACC_W];
    assign acc_new = acc_sat ? ACC_MAX : acc_sum[ACC_W-1:0];

    ssopa_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    ssopa_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_plus_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (plus_wdata),
        .re    (accept),
        .raddr (idx_now),
        .rdata (plus_rdata)
    );

    ssopa_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_minus_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (minus_wdata),
        .re    (accept),
        .raddr (idx_now),
        .rdata (minus_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        cmd_reg         <= cmd_next;
        ok_reg          <= ok_next;
        neg_reg         <= neg_next;
        ua_reg          <= ua_next;
        ux_reg          <= ux_next;
        ub_reg          <= ub_next;
        mag_reg         <= mag_next;
        plus_value_reg  <= plus_value_next;
        minus_value_reg <= minus_value_next;
        saturated_reg   <= saturated_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        ok_next          = ok_reg;
        neg_next         = neg_reg;
        ua_next          = ua_reg;
        ux_next          = ux_reg;
        ub_next          = ub_reg;
        mag_next         = mag_reg;
        out_valid_next   = out_valid_reg && out_stall;
        plus_value_next  = plus_value_reg;
        minus_value_next = minus_value_reg;
        saturated_next   = saturated_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        plus_wdata       = plus_rdata;
        minus_wdata      = minus_rdata;
        mul_en           = 1'b0;
        mul_a            = MUL_A_W'(ua_reg);
        mul_b            = ux_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = clr_cnt_reg;
                plus_wdata  = '0;
                minus_wdata = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = idx_now;
                    cmd_next = cmd;
                    ok_next  = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
                    neg_next = alpha[VAL_W-1] ^ a_value[VAL_W-1] ^ b_value[VAL_W-1];
                    ua_next  = alpha[VAL_W-1] ? VAL_W'(-alpha) : VAL_W'(alpha);
                    ux_next  = a_value[VAL_W-1] ? VAL_W'(-a_value) : VAL_W'(a_value);
                    ub_next  = b_value[VAL_W-1] ? VAL_W'(-b_value) : VAL_W'(b_value);
                    if ((cmd == CMD_ACC) && ok_next)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MUL1:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(ua_reg);
                mul_b      = ux_reg;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = mul_p[MUL_A_W-1:0];
                mul_b      = ub_reg;
                state_next = S_RND;
            end
            S_RND:
            begin
                mag_next   = rnd_sum[EXACT_W-1:RND_SH];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (!ok_reg)
                    begin
                        plus_value_next  = '0;
                        minus_value_next = '0;
                        saturated_next   = 1'b0;
                    end
                    else if (cmd_reg == CMD_ACC)
                    begin
                        ram_we      = 1'b1;
                        plus_wdata  = neg_reg ? plus_rdata : acc_new;
                        minus_wdata = neg_reg ? acc_new : minus_rdata;
                        plus_value_next  = plus_wdata;
                        minus_value_next = minus_wdata;
                        saturated_next   = acc_sat;
                    end
                    else if (cmd_reg == CMD_CLEAR)
                    begin
                        ram_we      = 1'b1;
                        plus_wdata  = '0;
                        minus_wdata = '0;
                        plus_value_next  = '0;
                        minus_value_next = '0;
                        saturated_next   = 1'b0;
                    end
                    else
                    begin
                        plus_value_next  = plus_rdata;
                        minus_value_next = minus_rdata;
                        saturated_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign plus_value  = plus_value_reg;
    assign minus_value = minus_value_reg;
    assign saturated   = saturated_reg;

    a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> plus_value == ACC_MAX || minus_value == ACC_MAX)
        else $error("saturated result without a clipped accumulator");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL1 || state_reg == S_DONE)
        else $error("transfer did not start the sequencer");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("store written while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside write-back");

endmodule
